[hw/rtl/nps_pkg.sv]
// Package for the next prime search block.
// Holds default widths, search constants and the controller/datapath interface structs.
package nps_pkg;

    localparam int NPS_VALUE_WIDTH   = 32;
    localparam int NPS_FIRST_DIVISOR = 2;
    localparam int NPS_FIRST_SQUARE  = 4;
    localparam int NPS_SMALL_LIMIT   = 2;

    typedef struct packed {
        logic load;
        logic div_start;
        logic next_divisor;
        logic next_candidate;
        logic out_load;
        logic out_zero;
    } nps_cmd_t;

    typedef struct packed {
        logic root_passed;
        logic div_done;
        logic rem_zero;
        logic cand_max;
    } nps_status_t;

endpackage

[hw/rtl/nps_divider.sv]
// Iterative restoring remainder unit, one quotient bit per cycle.
// Used by the next prime search datapath; depends on nothing else.
module nps_divider #(
    parameter int DW = 31
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] remainder
);

    localparam int CW = $clog2(DW + 1);

    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0] dvd_reg, dvd_next;
    logic [DW-1:0] dsr_reg, dsr_next;
    logic [DW-1:0] rem_reg, rem_next;
    logic [DW:0]   shifted;
    logic [DW:0]   diff;

    assign shifted = {rem_reg, dvd_reg[DW-1]};
    assign diff    = shifted - {1'b0, dsr_reg};

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CW'(DW);
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
        end else if (busy_reg) begin
            dvd_next = {dvd_reg[DW-2:0], 1'b0};
            if (shifted >= {1'b0, dsr_reg}) begin
                rem_next = diff[DW-1:0];
            end else begin
                rem_next = shifted[DW-1:0];
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

[hw/rtl/nps_datapath.sv]
// Datapath of the next prime search: candidate, divisor, running square and result.
// Depends on nps_pkg and nps_divider.
module nps_datapath
    import nps_pkg::*;
#(
    parameter int VALUE_WIDTH = NPS_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  nps_cmd_t                      cmd,
    input  logic signed [VALUE_WIDTH-1:0] start_value,
    output nps_status_t                   status,
    output logic        [VALUE_WIDTH-2:0] prime_found
);

    localparam int DW = VALUE_WIDTH - 1;
    localparam int SW = DW + 1;

    logic [DW-1:0] cand_reg, cand_next;
    logic [DW-1:0] div_reg, div_next;
    logic [SW-1:0] sq_reg, sq_next;
    logic [DW-1:0] out_reg;
    logic          small_start;
    logic          div_done;
    logic [DW-1:0] remainder;

    assign small_start = start_value[VALUE_WIDTH-1]
                       | (start_value[DW-1:0] <= DW'(NPS_SMALL_LIMIT));

    always_comb begin
        cand_next = cand_reg;
        div_next  = div_reg;
        sq_next   = sq_reg;
        if (cmd.load) begin
            cand_next = small_start ? DW'(NPS_SMALL_LIMIT) : start_value[DW-1:0];
            div_next  = DW'(NPS_FIRST_DIVISOR);
            sq_next   = SW'(NPS_FIRST_SQUARE);
        end else if (cmd.next_candidate) begin
            cand_next = cand_reg + DW'(1);
            div_next  = DW'(NPS_FIRST_DIVISOR);
            sq_next   = SW'(NPS_FIRST_SQUARE);
        end else if (cmd.next_divisor) begin
            div_next = div_reg + DW'(1);
            sq_next  = sq_reg + {div_reg, 1'b1};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '0;
            div_reg  <= '0;
            sq_reg   <= '0;
        end else begin
            cand_reg <= cand_next;
            div_reg  <= div_next;
            sq_reg   <= sq_next;
        end
        if (cmd.out_load) begin
            out_reg <= cmd.out_zero ? '0 : cand_reg;
        end
    end

    nps_divider #(
        .DW(DW)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (cand_reg),
        .divisor  (div_reg),
        .done     (div_done),
        .remainder(remainder)
    );

    assign status.root_passed = sq_reg > {1'b0, cand_reg};
    assign status.div_done    = div_done;
    assign status.rem_zero    = (remainder == '0);
    assign status.cand_max    = &cand_reg;
    assign prime_found        = out_reg;

endmodule

[hw/rtl/nps_ctrl.sv]
// Controller state machine of the next prime search.
// Depends on nps_pkg; drives the datapath through command and status structs.
module nps_ctrl
    import nps_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    output logic        m_valid,
    input  logic        m_ready,
    input  nps_status_t status,
    output nps_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_FOUND,
        ST_FAIL
    } state_t;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    logic   out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.root_passed) begin
                    state_next = ST_FOUND;
                end else begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
            end
            ST_DIVIDE: begin
                if (status.div_done) begin
                    if (!status.rem_zero) begin
                        cmd.next_divisor = 1'b1;
                        state_next       = ST_CHECK;
                    end else if (status.cand_max) begin
                        state_next = ST_FAIL;
                    end else begin
                        cmd.next_candidate = 1'b1;
                        state_next         = ST_CHECK;
                    end
                end
            end
            ST_FOUND, ST_FAIL: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_zero = (state_reg == ST_FAIL);
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;

endmodule

[hw/rtl/next_prime_search_top.sv]
// Next prime search: smallest prime not below a signed start value, by trial division.
// Each tried divisor passes through the check state and a run of the serial remainder unit;
// a found prime is loaded into the output register once that register is free.
// The block works on one beat at a time, and the serial remainder unit sets the rate.
// A new beat is taken while the previous result still waits in the output register.
// Reset (aresetn, synchronous, active low) returns the block to idle with no result pending.
module next_prime_search_top
    import nps_pkg::*;
#(
    parameter int VALUE_WIDTH = NPS_VALUE_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_start_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic        [VALUE_WIDTH-2:0] m_prime_found
);

    nps_cmd_t    cmd;
    nps_status_t status;

    nps_ctrl u_ctrl (
        .aclk   (aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .status (status),
        .cmd    (cmd)
    );

    nps_datapath #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .start_value(s_start_value),
        .status     (status),
        .prime_found(m_prime_found)
    );

endmodule

[sim/nps_result_checker.sv]
// Result checker for the next prime search block: watches both channels, predicts each prime
// by its own trial division and compares every result beat. Depends on nps_pkg for widths and search constants.
module nps_result_checker
    import nps_pkg::*;
#(
    parameter int VW = NPS_VALUE_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic signed [VW-1:0] s_start_value,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  logic        [VW-2:0] m_prime_found,
    output int                   fail_count,
    output int                   pending_count
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [VW-2:0] expected_primes [$];
    int            mismatches = 0;
    logic [VW-2:0] oldest_prime;

    function automatic logic [VW-2:0] smallest_prime_from(input logic signed [VW-1:0] start);
        longint unsigned cand;
        longint unsigned divisor;
        longint unsigned max_pos;
        bit              found;
        max_pos = (64'd1 << (VW - 1)) - 1;
        if (start <= NPS_SMALL_LIMIT) begin
            return (VW - 1)'(NPS_SMALL_LIMIT);
        end
        cand  = longint'(start);
        found = 1'b0;
        while (!found && cand <= max_pos) begin
            found = 1'b1;
            for (divisor = NPS_FIRST_DIVISOR; divisor * divisor <= cand; divisor++) begin
                if (cand % divisor == 0) begin
                    found = 1'b0;
                    break;
                end
            end
            if (!found) begin
                cand++;
            end
        end
        return found ? cand[VW-2:0] : '0;
    endfunction

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_primes.push_back(smallest_prime_from(s_start_value));
            end
            if (m_valid && m_ready) begin
                if (expected_primes.size() == 0) begin
                    mismatches++;
                    $display("%0t: unexpected result beat, actual %0d", $time, m_prime_found);
                end else begin
                    oldest_prime = expected_primes.pop_front();
                    if (m_prime_found !== oldest_prime) begin
                        mismatches++;
                        $display("%0t: prime_found expected %0d, actual %0d",
                                 $time, oldest_prime, m_prime_found);
                    end
                end
            end
        end
        fail_count    <= mismatches;
        pending_count <= expected_primes.size();
    end

endmodule

[sim/tb_next_prime_search_top.sv]
// Testbench top for next_prime_search_top: clock, reset, bursty start values and a stalling
// receiver with one long hold-off. Depends on nps_pkg, nps_result_checker and next_prime_search_top.
module tb_next_prime_search_top
    import nps_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW          = NPS_VALUE_WIDTH;
    localparam int RANDOM_ITEMS = 100;
    localparam int CYCLE_LIMIT = 30_000_000;
    localparam int HOLD_AT     = 40;
    localparam int HOLD_CYCLES = 20_000;
    localparam int TAIL_CYCLES = 40;

    localparam logic signed [VW-1:0] DIRECTED_STARTS [20] = '{
        32'sh80000000, 32'shFFFFFFFF, 32'shFFFFFFFE, 32'sd0, 32'sd1,
        32'sd2, 32'sd3, 32'sd4, 32'sd5, 32'sd8,
        32'sd9, 32'sd24, 32'sd25, 32'sd90, 32'sd113,
        32'sd114, 32'sd1000, 32'sd4093, 32'sd65536, 32'sd2147483647
    };

    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic signed [VW-1:0] s_start_value = '0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic        [VW-2:0] m_prime_found;

    int fail_count;
    int pending_count;
    int burst_left  = 0;
    int cycle_count = 0;

    always #6 aclk = ~aclk;

    next_prime_search_top #(
        .VALUE_WIDTH(VW)
    ) i_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_value(s_start_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime_found(m_prime_found)
    );

    nps_result_checker #(
        .VW(VW)
    ) i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_start_value(s_start_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_prime_found(m_prime_found),
        .fail_count   (fail_count),
        .pending_count(pending_count)
    );

    task automatic offer_start(input logic signed [VW-1:0] value);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid       <= 1'b1;
        s_start_value <= value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic signed [VW-1:0] random_start();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            return {1'b1, (VW - 1)'($urandom)};
        end else if (pick < 15) begin
            return VW'($urandom_range(0, 4)) - VW'(2);
        end else if (pick < 85) begin
            return VW'($urandom_range(3, 4095));
        end else if (pick < 95) begin
            return VW'($urandom_range(4096, 65535));
        end
        return VW'($urandom_range(65536, 1 << 20));
    endfunction

    // The receiver holds off once for a long stretch so that the block fills and stalls
    // its input; otherwise it picks a new stall pattern each time its phase counter wraps.
    initial begin
        int  beats;
        int  mode;
        int  phase;
        bit  held;
        beats = 0;
        mode  = 0;
        phase = 0;
        held  = 1'b0;
        @(posedge aresetn);
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready) begin
                beats++;
            end
            if (beats == HOLD_AT && !held) begin
                held = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else begin
                if (phase == 0) begin
                    mode = $urandom_range(0, 2);
                end
                phase = (phase + 1) % 64;
                case (mode)
                    0: begin
                        m_ready <= 1'b1;
                    end
                    1: begin
                        m_ready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        m_ready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("next_prime_search_top: mismatch");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (DIRECTED_STARTS[i]) begin
            offer_start(DIRECTED_STARTS[i]);
        end
        repeat (RANDOM_ITEMS) begin
            offer_start(random_start());
        end
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("next_prime_search_top: match");
        end else begin
            $display("next_prime_search_top: mismatch");
        end
        $finish;
    end

endmodule
